FILE: rtl/sqora_pkg.sv
// ============================================================================
// sqora_pkg: shared types and constants of the send-queue overflow rate adapter
// Word layouts, register indexes, rate and bitrate ladders, percent scaling.
// ============================================================================
package sqora_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RATE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RATE_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CRITICAL_TH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WARNING_TH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AUDIO_ENABLED  = 3'd4;
    localparam int unsigned CFG_DATA_W = 8;

    // Register reset values
    localparam logic [6:0] MIN_RATE_RST       = 7'd1;
    localparam logic [6:0] MAX_RATE_LIMIT_RST = 7'd30;
    localparam logic [7:0] CRITICAL_TH_RST    = 8'd12;
    localparam logic [7:0] WARNING_TH_RST     = 8'd2;
    localparam logic       AUDIO_ENABLED_RST  = 1'b1;

    // Rate ladder
    localparam logic [7:0] RATE_HIGH    = 8'd25;
    localparam logic [7:0] RATE_MID     = 8'd20;
    localparam logic [7:0] RATE_LOW     = 8'd15;
    localparam logic [7:0] RATE_SCALE70 = 8'd10;

    // Overflow ticks beyond which a warning steps down regardless of trend
    localparam logic [7:0] OVF_PATIENCE = 8'd10;

    // Normal-operation cadence
    localparam int unsigned STEP_UP_PERIOD = 10;
    localparam int unsigned CEIL_PERIOD    = 30;
    localparam int unsigned UP_PHASE_W     = $clog2(STEP_UP_PERIOD);
    localparam int unsigned CEIL_PHASE_W   = $clog2(CEIL_PERIOD);
    localparam logic [UP_PHASE_W-1:0]   UP_PHASE_LAST   = UP_PHASE_W'(STEP_UP_PERIOD - 1);
    localparam logic [CEIL_PHASE_W-1:0] CEIL_PHASE_LAST = CEIL_PHASE_W'(CEIL_PERIOD - 1);
    localparam int unsigned NORMAL_CNT_W = 32;

    // Audio bitrate ladder
    localparam logic [16:0] BR_96K = 17'(96 * 1024);
    localparam logic [16:0] BR_64K = 17'(64 * 1024);
    localparam logic [16:0] BR_32K = 17'(32 * 1024);
    localparam logic [16:0] BR_24K = 17'(24 * 1024);

    // Percent scaling: floor(v * p / 100) as v * (p * RECIP) >> SHIFT.
    // Exact for v * p below 2^22, which covers a 15-bit size times 90.
    localparam int unsigned PCT_SHIFT = 29;
    localparam int unsigned PCT_RECIP = ((1 << PCT_SHIFT) + 99) / 100;
    localparam int unsigned PCT_K_W   = 29;
    localparam int unsigned PCT_PROD_W = 15 + PCT_K_W;
    localparam logic [PCT_K_W-1:0] PCT_K70 = PCT_K_W'(70 * PCT_RECIP);
    localparam logic [PCT_K_W-1:0] PCT_K80 = PCT_K_W'(80 * PCT_RECIP);
    localparam logic [PCT_K_W-1:0] PCT_K90 = PCT_K_W'(90 * PCT_RECIP);

    localparam logic [1:0] PCT_70 = 2'd0;
    localparam logic [1:0] PCT_80 = 2'd1;
    localparam logic [1:0] PCT_90 = 2'd2;

    typedef struct packed {
        logic [15:0] queue_depth;
        logic [7:0]  current_rate;
        logic [18:0] audio_bitrate;
        logic [14:0] source_width;
        logic [14:0] source_height;
    } tick_t;

    typedef struct packed {
        logic        rate_change_valid;
        logic [7:0]  new_rate;
        logic        bitrate_change_valid;
        logic [16:0] new_bitrate;
        logic [14:0] forced_width_out;
        logic [14:0] forced_height_out;
        logic [7:0]  rate_ceiling_out;
        logic        critical_out;
        logic        keyframe_request;
    } result_t;

    typedef struct packed {
        logic [6:0] min_rate;
        logic [6:0] max_rate_limit;
        logic [7:0] critical_threshold;
        logic [7:0] warning_threshold;
        logic       audio_enabled;
    } cfg_t;

    typedef struct packed {
        logic                    critical_flag;
        logic [NORMAL_CNT_W-1:0] normal_ticks;
        logic [UP_PHASE_W-1:0]   up_phase;
        logic [CEIL_PHASE_W-1:0] ceil_phase;
        logic [7:0]              overflow_ticks;
        logic [15:0]             previous_depth;
        logic [7:0]              rate_ceiling;
        logic [14:0]             forced_width;
        logic [14:0]             forced_height;
    } state_t;

    function automatic logic [14:0] pct_scale(input logic [14:0] v, input logic [1:0] code);
        logic [PCT_K_W-1:0]    k;
        logic [PCT_PROD_W-1:0] prod;
        case (code)
            PCT_70:  k = PCT_K70;
            PCT_80:  k = PCT_K80;
            default: k = PCT_K90;
        endcase
        prod = PCT_PROD_W'(v) * PCT_PROD_W'(k);
        return prod[PCT_SHIFT +: 15];
    endfunction

endpackage

FILE: rtl/sqora_cfg_if.sv
// ============================================================================
// sqora_cfg_if: configuration write channel
// Register index and write data with a valid/ready handshake.
// ============================================================================
interface sqora_cfg_if import sqora_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;

    modport source (output valid, index, wdata, input ready);
    modport sink   (input valid, index, wdata, output ready);
endinterface

FILE: rtl/sqora_tick_if.sv
// ============================================================================
// sqora_tick_if: tick input channel
// One word per tick: queue depth, rate, bitrate and source frame size.
// ============================================================================
interface sqora_tick_if import sqora_pkg::*; ();
    logic  valid;
    logic  ready;
    tick_t data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/sqora_result_if.sv
// ============================================================================
// sqora_result_if: result output channel
// One word per tick: rate and bitrate requests, forced size, status.
// ============================================================================
interface sqora_result_if import sqora_pkg::*; ();
    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/sqora_cfg_regs.sv
// ============================================================================
// sqora_cfg_regs: configuration register file
// Decodes writes on the configuration channel into the five registers.
// ============================================================================
module sqora_cfg_regs import sqora_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    sqora_cfg_if.sink   cfg,
    output cfg_t        regs
);

    cfg_t regs_reg;
    logic wr_en;

    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.min_rate           <= MIN_RATE_RST;
            regs_reg.max_rate_limit     <= MAX_RATE_LIMIT_RST;
            regs_reg.critical_threshold <= CRITICAL_TH_RST;
            regs_reg.warning_threshold  <= WARNING_TH_RST;
            regs_reg.audio_enabled      <= AUDIO_ENABLED_RST;
        end
        else if (wr_en)
        begin
            // Drop writes to indexes beyond the register list
            unique case (cfg.index)
                REG_MIN_RATE:       regs_reg.min_rate           <= cfg.wdata[6:0];
                REG_MAX_RATE_LIMIT: regs_reg.max_rate_limit     <= cfg.wdata[6:0];
                REG_CRITICAL_TH:    regs_reg.critical_threshold <= cfg.wdata;
                REG_WARNING_TH:     regs_reg.warning_threshold  <= cfg.wdata;
                REG_AUDIO_ENABLED:  regs_reg.audio_enabled      <= cfg.wdata[0];
                default:            ;
            endcase
        end
    end

endmodule

FILE: rtl/sqora_step.sv
// ============================================================================
// sqora_step: per-tick decision logic
// Classifies one tick and computes the result word and the next state.
// ============================================================================
module sqora_step import sqora_pkg::*;
(
    input  cfg_t    regs,
    input  state_t  cur,
    input  tick_t   tick,
    output state_t  nxt,
    output result_t res
);

    logic        is_crit;
    logic        is_warn;
    logic [7:0]  ovf_inc;
    logic        do_down;
    logic        do_up;
    logic        flag_for_down;
    logic        down_ok;
    logic [7:0]  down_rate;
    logic        up_ok;
    logic [7:0]  up_rate;
    logic [8:0]  ceil_plus;
    logic        pct_load;
    logic [1:0]  pct_code;

    assign is_crit = tick.queue_depth > {8'd0, regs.critical_threshold};
    assign is_warn = tick.queue_depth > {8'd0, regs.warning_threshold};
    assign ovf_inc = (cur.overflow_ticks == 8'hFF) ? cur.overflow_ticks
                                                   : cur.overflow_ticks + 8'd1;
    assign ceil_plus = {1'b0, cur.rate_ceiling} + 9'd1;

    // Step-down rate ladder
    assign down_ok = tick.current_rate > {1'b0, regs.min_rate};
    always_comb
    begin
        if (!down_ok)
            down_rate = tick.current_rate;
        else if (tick.current_rate >= RATE_HIGH)
            down_rate = RATE_MID;
        else if (tick.current_rate >= RATE_MID)
            down_rate = RATE_LOW;
        else
            down_rate = tick.current_rate - 8'd1;
    end

    always_comb
    begin
        nxt            = cur;
        res            = '0;
        do_down        = 1'b0;
        do_up          = 1'b0;
        flag_for_down  = cur.critical_flag;
        pct_load       = 1'b0;
        pct_code       = PCT_90;
        up_ok          = 1'b0;
        up_rate        = tick.current_rate;

        nxt.previous_depth = tick.queue_depth;

        if (is_crit)
        begin
            nxt.critical_flag  = 1'b1;
            nxt.normal_ticks   = '0;
            nxt.up_phase       = '0;
            nxt.ceil_phase     = '0;
            nxt.overflow_ticks = ovf_inc;
            flag_for_down      = 1'b1;
            do_down            = 1'b1;
        end
        else if (is_warn)
        begin
            nxt.normal_ticks   = '0;
            nxt.up_phase       = '0;
            nxt.ceil_phase     = '0;
            nxt.overflow_ticks = ovf_inc;
            do_down = (tick.queue_depth > cur.previous_depth) || (ovf_inc > OVF_PATIENCE);
        end
        else if ((cur.overflow_ticks != 8'd0) && (tick.queue_depth == 16'd0))
        begin
            res.keyframe_request = cur.critical_flag;
            nxt.critical_flag    = 1'b0;
            nxt.normal_ticks     = NORMAL_CNT_W'(1);
            nxt.up_phase         = UP_PHASE_W'(1);
            nxt.ceil_phase       = CEIL_PHASE_W'(1);
            nxt.overflow_ticks   = 8'd0;
        end
        else if (cur.normal_ticks != '0)
        begin
            if (cur.normal_ticks == '1)
            begin
                // Wrap to one and restart the cadence
                nxt.normal_ticks = NORMAL_CNT_W'(1);
                nxt.up_phase     = UP_PHASE_W'(1);
                nxt.ceil_phase   = CEIL_PHASE_W'(1);
            end
            else
            begin
                nxt.normal_ticks = cur.normal_ticks + NORMAL_CNT_W'(1);
                nxt.up_phase     = (cur.up_phase == UP_PHASE_LAST) ? '0
                                   : cur.up_phase + UP_PHASE_W'(1);
                nxt.ceil_phase   = (cur.ceil_phase == CEIL_PHASE_LAST) ? '0
                                   : cur.ceil_phase + CEIL_PHASE_W'(1);
                if (cur.ceil_phase == CEIL_PHASE_LAST)
                begin
                    nxt.rate_ceiling = (ceil_plus < {2'b0, regs.max_rate_limit})
                                       ? ceil_plus[7:0] : {1'b0, regs.max_rate_limit};
                end
                do_up = (cur.up_phase == UP_PHASE_LAST);
            end
        end

        if (do_down)
        begin
            if (down_ok)
            begin
                if (flag_for_down)
                    nxt.rate_ceiling = down_rate;
                res.rate_change_valid = 1'b1;
                res.new_rate          = down_rate;
            end
            if ((down_rate < RATE_HIGH) && regs.audio_enabled)
            begin
                if (tick.audio_bitrate >= {2'b0, BR_96K})
                begin
                    res.bitrate_change_valid = 1'b1;
                    res.new_bitrate          = BR_64K;
                end
                else if (tick.audio_bitrate >= {2'b0, BR_64K})
                begin
                    res.bitrate_change_valid = 1'b1;
                    res.new_bitrate          = BR_32K;
                end
                else if (tick.audio_bitrate >= {2'b0, BR_32K})
                begin
                    res.bitrate_change_valid = 1'b1;
                    res.new_bitrate          = BR_24K;
                end
            end
            if (down_rate < RATE_MID)
            begin
                pct_load = 1'b1;
                if (down_rate < RATE_SCALE70)
                    pct_code = PCT_70;
                else if (down_rate < RATE_LOW)
                    pct_code = PCT_80;
                else
                    pct_code = PCT_90;
            end
        end

        if (do_up)
        begin
            // Ceiling raise above (if any) already applies here
            up_ok   = tick.current_rate < nxt.rate_ceiling;
            up_rate = up_ok ? tick.current_rate + 8'd1 : tick.current_rate;
            if (up_ok)
            begin
                res.rate_change_valid = 1'b1;
                res.new_rate          = up_rate;
            end
            if ((up_rate >= RATE_HIGH) && regs.audio_enabled)
            begin
                if (tick.audio_bitrate < {2'b0, BR_32K})
                begin
                    res.bitrate_change_valid = 1'b1;
                    res.new_bitrate          = BR_32K;
                end
                else if (tick.audio_bitrate < {2'b0, BR_64K})
                begin
                    res.bitrate_change_valid = 1'b1;
                    res.new_bitrate          = BR_64K;
                end
                else if (tick.audio_bitrate < {2'b0, BR_96K})
                begin
                    res.bitrate_change_valid = 1'b1;
                    res.new_bitrate          = BR_96K;
                end
            end
            if ((cur.forced_width != 15'd0) && (cur.forced_height != 15'd0))
            begin
                if (up_rate >= RATE_HIGH)
                begin
                    nxt.forced_width  = 15'd0;
                    nxt.forced_height = 15'd0;
                end
                else if (up_rate >= RATE_MID)
                begin
                    pct_load = 1'b1;
                    pct_code = PCT_90;
                end
                else if (up_rate >= RATE_LOW)
                begin
                    pct_load = 1'b1;
                    pct_code = PCT_80;
                end
            end
        end

        if (pct_load)
        begin
            nxt.forced_width  = pct_scale(tick.source_width, pct_code);
            nxt.forced_height = pct_scale(tick.source_height, pct_code);
        end

        res.forced_width_out  = nxt.forced_width;
        res.forced_height_out = nxt.forced_height;
        res.rate_ceiling_out  = nxt.rate_ceiling;
        res.critical_out      = nxt.critical_flag;
    end

endmodule

FILE: rtl/send_queue_overflow_rate_adapter_top.sv
// ============================================================================
// send_queue_overflow_rate_adapter_top: send-queue overflow rate adapter
// Adapts capture rate, audio bitrate and forced frame size to queue depth.
// ============================================================================
// Each word on tick_in carries the send-queue depth, the capture rate, the
// audio bitrate and the source frame size for one tick; each tick gives
// exactly one word on result_out. The block accepts one tick per clock while
// result_out is not stalled. A tick is captured in the input register; the
// whole decision (classification, rate and bitrate ladders, percent scaling
// of the frame size) is evaluated combinationally from it and lands in the
// result register together with the updated adapter state, so the next tick
// sees that state with no bubble. A stalled
// result_out holds the pipeline; tick_in.ready follows result_out.ready
// combinationally when both registers are full. Configuration writes on cfg
// are always ready and take effect on the next tick; write them only while
// no tick is in flight. Writing max_rate_limit leaves the adaptive ceiling
// where it is until the next 30-tick raise.
// ============================================================================
module send_queue_overflow_rate_adapter_top import sqora_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    sqora_cfg_if.sink       cfg,
    sqora_tick_if.sink      tick_in,
    sqora_result_if.source  result_out
);

    cfg_t    regs;
    tick_t   tick_reg;
    logic    tick_valid_reg;
    logic    tick_valid_next;
    result_t result_reg;
    logic    result_valid_reg;
    logic    result_valid_next;
    state_t  state_reg;
    state_t  state_next;
    result_t result_next;
    logic    advance;
    logic    tick_fire;

    sqora_cfg_regs u_cfg_regs
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    sqora_step u_step
    (
        .regs (regs),
        .cur  (state_reg),
        .tick (tick_reg),
        .nxt  (state_next),
        .res  (result_next)
    );

    // Advance the captured tick whenever the result register is free or drains
    assign advance       = tick_valid_reg && (!result_valid_reg || result_out.ready);
    assign tick_in.ready = !tick_valid_reg || advance;
    assign tick_fire     = tick_in.valid && tick_in.ready;

    assign tick_valid_next   = tick_fire || (tick_valid_reg && !advance);
    assign result_valid_next = advance || (result_valid_reg && !result_out.ready);

    assign result_out.valid = result_valid_reg;
    assign result_out.data  = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            tick_valid_reg   <= tick_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Adapter state: moves only when a tick is committed to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.critical_flag  <= 1'b0;
            state_reg.normal_ticks   <= '0;
            state_reg.up_phase       <= '0;
            state_reg.ceil_phase     <= '0;
            state_reg.overflow_ticks <= '0;
            state_reg.previous_depth <= '0;
            state_reg.rate_ceiling   <= {1'b0, MAX_RATE_LIMIT_RST};
            state_reg.forced_width   <= '0;
            state_reg.forced_height  <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (tick_fire)
            tick_reg <= tick_in.data;
        if (advance)
            result_reg <= result_next;
    end

endmodule
